FILE: sv/ucer_pkg.sv
// Package for the USB control endpoint responder: types, action and request codes,
// descriptor ROM contents. No dependencies.
package ucer_pkg;

  localparam int MaxPacketDef = 64;
  localparam int RomBytesDef  = 128;

  typedef enum logic [1:0] {
    OP_BUS_RESET = 2'd0,
    OP_SETUP     = 2'd1,
    OP_IN_DONE   = 2'd2,
    OP_OUT_DONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_DATA   = 3'd1,
    ACT_ZLP    = 3'd2,
    ACT_ARMOUT = 3'd3,
    ACT_STALL  = 3'd4,
    ACT_SETADR = 3'd5
  } act_t;

  localparam logic [7:0] REQ_GET_STATUS  = 8'h00;
  localparam logic [7:0] REQ_CLR_FEATURE = 8'h01;
  localparam logic [7:0] REQ_SET_FEATURE = 8'h03;
  localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
  localparam logic [7:0] REQ_GET_DESC    = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIG  = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;
  localparam logic [7:0] REQ_GET_IFACE   = 8'h0a;
  localparam logic [7:0] REQ_SET_IFACE   = 8'h0b;
  localparam logic [7:0] REQ_SET_LINE    = 8'h20;
  localparam logic [7:0] REQ_GET_LINE    = 8'h21;
  localparam logic [1:0] TYP_STANDARD    = 2'd0;
  localparam logic [1:0] TYP_CLASS       = 2'd1;

  localparam logic [55:0] LC_RESET = 56'h08_0000_0001_C200;

  // One item as it leaves the block.
  typedef struct packed {
    act_t       action;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic [6:0] packet_length;
    logic       pid_data1;
    logic       status_out_armed;
    logic [6:0] device_address;
    logic       is_configured;
    logic       last;
  } res_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_evt;   // decode the event held in the input register
    logic emit_pkt;   // emit the next byte of the current packet
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic pkt_mode;   // event needs a packet burst
    logic pkt_done;   // current byte is the last of the packet
  } sts_t;

  function automatic logic [7:0] rom_byte(input logic [8:0] a);
    logic [7:0] r;
    r = 8'h00;
    unique case (a)
      9'd0: r=8'd18;  9'd1: r=8'h01; 9'd2: r=8'h00; 9'd3: r=8'h02; 9'd4: r=8'h02;
      9'd5: r=8'h00;  9'd6: r=8'h00; 9'd7: r=8'd64; 9'd8: r=8'h09; 9'd9: r=8'h12;
      9'd10: r=8'hE0; 9'd11: r=8'hC1; 9'd12: r=8'h00; 9'd13: r=8'h01; 9'd14: r=8'd1;
      9'd15: r=8'd2;  9'd16: r=8'd0; 9'd17: r=8'd1;
      9'd18: r=8'd9;  9'd19: r=8'h02; 9'd20: r=8'd67; 9'd21: r=8'd0; 9'd22: r=8'd2;
      9'd23: r=8'd1;  9'd24: r=8'd0; 9'd25: r=8'h80; 9'd26: r=8'd50;
      9'd27: r=8'd9;  9'd28: r=8'h04; 9'd29: r=8'd0; 9'd30: r=8'd0; 9'd31: r=8'd1;
      9'd32: r=8'h02; 9'd33: r=8'h02; 9'd34: r=8'h01; 9'd35: r=8'd0;
      9'd36: r=8'd5;  9'd37: r=8'h24; 9'd38: r=8'h00; 9'd39: r=8'h10; 9'd40: r=8'h01;
      9'd41: r=8'd5;  9'd42: r=8'h24; 9'd43: r=8'h01; 9'd44: r=8'h00; 9'd45: r=8'd1;
      9'd46: r=8'd4;  9'd47: r=8'h24; 9'd48: r=8'h02; 9'd49: r=8'h02;
      9'd50: r=8'd5;  9'd51: r=8'h24; 9'd52: r=8'h06; 9'd53: r=8'd0; 9'd54: r=8'd1;
      9'd55: r=8'd7;  9'd56: r=8'h05; 9'd57: r=8'h81; 9'd58: r=8'h03; 9'd59: r=8'd8;
      9'd60: r=8'd0;  9'd61: r=8'd16;
      9'd62: r=8'd9;  9'd63: r=8'h04; 9'd64: r=8'd1; 9'd65: r=8'd0; 9'd66: r=8'd2;
      9'd67: r=8'h0A; 9'd68: r=8'h00; 9'd69: r=8'h00; 9'd70: r=8'd0;
      9'd71: r=8'd7;  9'd72: r=8'h05; 9'd73: r=8'h82; 9'd74: r=8'h02; 9'd75: r=8'd64;
      9'd76: r=8'd0;  9'd77: r=8'd0;
      9'd78: r=8'd7;  9'd79: r=8'h05; 9'd80: r=8'h03; 9'd81: r=8'h02; 9'd82: r=8'd64;
      9'd83: r=8'd0;  9'd84: r=8'd0;
      9'd85: r=8'd4;  9'd86: r=8'h03; 9'd87: r=8'h09; 9'd88: r=8'h04;
      9'd89: r=8'd10; 9'd90: r=8'h03; 9'd91: r=8'h4B; 9'd92: r=8'd0; 9'd93: r=8'h6C;
      9'd94: r=8'd0;  9'd95: r=8'h69; 9'd96: r=8'd0; 9'd97: r=8'h6E; 9'd98: r=8'd0;
      9'd99: r=8'd16; 9'd100: r=8'h03; 9'd101: r=8'h55; 9'd102: r=8'd0; 9'd103: r=8'h53;
      9'd104: r=8'd0; 9'd105: r=8'h42; 9'd106: r=8'd0; 9'd107: r=8'h20; 9'd108: r=8'd0;
      9'd109: r=8'h43; 9'd110: r=8'd0; 9'd111: r=8'h44; 9'd112: r=8'd0; 9'd113: r=8'h43;
      9'd114: r=8'd0;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/ucer_if.sv
// Valid/ready channel interfaces for the responder's input and result items.
// Depends on ucer_pkg.
interface ucer_in_if import ucer_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] packet_bytes;
  logic [9:0]  out_length;
  modport source (output valid, operation, packet_bytes, out_length, input ready);
  modport sink (input valid, operation, packet_bytes, out_length, output ready);
endinterface

interface ucer_out_if import ucer_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: sv/ucer_ctrl.sv
// Controller state machine of the responder: sequences event decode and packet bursts.
// Depends on ucer_pkg.
module ucer_ctrl import ucer_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic slot_free,   // result register empty or being taken
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DEC  = 3'b010,
    S_PKT  = 3'b100
  } st_t;

  st_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) state_nxt = S_DEC;
      end
      S_DEC: begin
        if (slot_free) begin
          cmd.load_evt = 1'b1;
          if (sts.pkt_mode) state_nxt = S_PKT;
          else state_nxt = S_IDLE;
        end
      end
      S_PKT: begin
        if (slot_free) begin
          cmd.emit_pkt = 1'b1;
          if (sts.pkt_done) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  a_load_only_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_evt |-> state_r == S_DEC) else $error("decode outside decode state");
  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_evt && cmd.emit_pkt)) else $error("decode and emit together");
  a_fire_to_dec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_DEC) else $error("accepted item not decoded");

endmodule

FILE: sv/ucer_dp.sv
// Datapath of the responder: endpoint state, request decode, descriptor and
// scratch byte source, result register. Depends on ucer_pkg.
module ucer_dp import ucer_pkg::*; #(
  parameter int MAX_PACKET = MaxPacketDef,
  parameter int ROM_BYTES  = RomBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_packet_bytes,
  input  logic [9:0]  in_out_length,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        slot_free,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_data
);

  localparam int PW = 9;  // pointer bits, covers ROM_BYTES up to 512

  logic [1:0]  op_r;
  logic [63:0] pk_r;
  logic [9:0]  olen_r;

  logic        cfg_r, stall_r, apply_r, active_r, pid_r, scr_r;
  logic [6:0]  padr_r, rem_r, n_r, idx_r;
  logic [PW-1:0] ptr_r;
  logic [55:0] lc_r;
  logic [55:0] scratch_r;
  logic        fin_r;

  logic        ov_r;
  res_t        res_r;

  assign slot_free = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_data  = res_r;

  // Setup fields.
  logic [7:0]  bm, req, lo, hi;
  logic [15:0] wl;
  logic        in_dir;
  logic [1:0]  typ;
  assign bm = pk_r[7:0];
  assign req = pk_r[15:8];
  assign lo = pk_r[23:16];
  assign hi = pk_r[31:24];
  assign wl = pk_r[63:48];
  assign in_dir = bm[7];
  assign typ = bm[6:5];

  // Decode result of a setup packet.
  typedef enum logic [2:0] {
    D_ZLP = 3'd0, D_STALL = 3'd1, D_ARMOUT = 3'd2, D_SEND = 3'd3
  } dk_t;
  dk_t        dk;
  logic       d_scr, d_setadr, d_setcfg, d_clrcfg;
  logic [PW-1:0] d_ptr;
  logic [6:0] d_len;
  logic [55:0] d_scratch;

  always_comb begin
    dk = D_STALL; d_scr = 1'b0; d_ptr = '0; d_len = '0; d_scratch = '0;
    d_setadr = 1'b0; d_setcfg = 1'b0; d_clrcfg = 1'b0;
    if (typ == TYP_STANDARD) begin
      priority case (req)
        REQ_SET_ADDRESS: begin dk = D_ZLP; d_setadr = 1'b1; end
        REQ_GET_DESC: if (in_dir) begin
          dk = D_SEND;
          if (hi == 8'd1 && lo == 8'd0) begin d_ptr = PW'(0); d_len = 7'd18; end
          else if (hi == 8'd2 && lo == 8'd0) begin d_ptr = PW'(18); d_len = 7'd67; end
          else if (hi == 8'd3 && lo == 8'd0) begin d_ptr = PW'(85); d_len = 7'd4; end
          else if (hi == 8'd3 && lo == 8'd1) begin d_ptr = PW'(89); d_len = 7'd10; end
          else if (hi == 8'd3 && lo == 8'd2) begin d_ptr = PW'(99); d_len = 7'd16; end
          else dk = D_STALL;
        end
        REQ_SET_CONFIG: if (!in_dir) begin
          dk = D_ZLP; d_setcfg = (lo == 8'd1); d_clrcfg = (lo == 8'd0);
        end
        REQ_GET_CONFIG: if (in_dir) begin
          dk = D_SEND; d_scr = 1'b1; d_len = 7'd1; d_scratch[0] = cfg_r;
        end
        REQ_GET_STATUS: if (in_dir) begin dk = D_SEND; d_scr = 1'b1; d_len = 7'd2; end
        REQ_GET_IFACE: if (in_dir) begin dk = D_SEND; d_scr = 1'b1; d_len = 7'd1; end
        REQ_SET_IFACE: if (!in_dir) dk = D_ZLP;
        REQ_CLR_FEATURE, REQ_SET_FEATURE: dk = D_ZLP;
        default: dk = D_STALL;
      endcase
    end else if (typ == TYP_CLASS) begin
      if (req == REQ_SET_LINE) begin
        if (!in_dir) dk = (wl >= 16'd7) ? D_ARMOUT : D_ZLP;
      end else if (req == REQ_GET_LINE) begin
        if (in_dir) begin dk = D_SEND; d_scr = 1'b1; d_len = 7'd7; d_scratch = lc_r; end
      end else if (!in_dir) dk = D_ZLP;
    end
  end

  // Remaining count clipped to wLength, then packet size.
  logic [6:0] s_rem, n_cur;
  assign s_rem = (wl < {9'd0, d_len}) ? wl[6:0] : d_len;
  assign n_cur = (rem_r > 7'(MAX_PACKET)) ? 7'(MAX_PACKET) : rem_r;

  // Byte source for the current position.
  logic [PW-1:0] pos;
  logic [7:0] src;
  assign pos = ptr_r + PW'(idx_r);
  always_comb begin
    if (scr_r) src = (pos < PW'(7)) ? scratch_r[pos[2:0]*8 +: 8] : 8'h00;
    else src = (int'(pos) < ROM_BYTES) ? rom_byte(pos) : 8'h00;
  end

  logic send_pkt;  // event starts a packet burst
  always_comb begin
    send_pkt = 1'b0;
    if (op_r == OP_SETUP && dk == D_SEND && s_rem != 7'd0) send_pkt = 1'b1;
    if (op_r == OP_IN_DONE && active_r && rem_r != 7'd0) send_pkt = 1'b1;
  end
  assign sts.pkt_mode = send_pkt;
  assign sts.pkt_done = (idx_r + 7'd1 == n_r);

  // A decoded event fills the result register unless a burst follows.
  logic ov_set;
  assign ov_set = cmd.emit_pkt || (cmd.load_evt && !send_pkt);

  function automatic res_t mk(input act_t a, input logic [6:0] len, input logic pid,
                               input logic st, input logic [6:0] adr, input logic cf);
    res_t r;
    r = '0;
    r.action = a; r.packet_length = len; r.pid_data1 = pid; r.status_out_armed = st;
    r.device_address = adr; r.is_configured = cf; r.last = 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_operation; pk_r <= in_packet_bytes; olen_r <= in_out_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= 1'b0; stall_r <= 1'b0; apply_r <= 1'b0; active_r <= 1'b0; pid_r <= 1'b1;
      scr_r <= 1'b0; padr_r <= '0; rem_r <= '0; ptr_r <= '0; lc_r <= LC_RESET;
      scratch_r <= '0; ov_r <= 1'b0; n_r <= '0; idx_r <= '0; fin_r <= 1'b0;
    end else begin
      ov_r <= ov_set || (ov_r && !out_ready);
      if (cmd.load_evt) begin
        idx_r <= '0;
        unique case (op_r)
          OP_BUS_RESET: begin
            cfg_r <= 1'b0; stall_r <= 1'b0; padr_r <= '0; apply_r <= 1'b0;
            active_r <= 1'b0; rem_r <= '0; ptr_r <= '0;
            res_r <= mk(ACT_NONE, 7'd0, 1'b0, 1'b0, 7'd0, 1'b0);
          end
          OP_SETUP: begin
            stall_r <= (dk == D_STALL);
            active_r <= send_pkt;
            rem_r <= send_pkt ? s_rem : 7'd0;
            if (d_setadr) begin padr_r <= lo[6:0]; apply_r <= 1'b1; end
            if (d_setcfg) cfg_r <= 1'b1;
            else if (d_clrcfg) cfg_r <= 1'b0;
            unique case (dk)
              D_ZLP: res_r <= mk(ACT_ZLP, 7'd0, 1'b1, 1'b0, 7'd0,
                                 d_setcfg | (cfg_r & ~d_clrcfg));
              D_ARMOUT: res_r <= mk(ACT_ARMOUT, 7'd7, 1'b1, 1'b0, 7'd0, cfg_r);
              D_STALL: res_r <= mk(ACT_STALL, 7'd0, 1'b0, 1'b0, 7'd0, cfg_r);
              D_SEND: begin
                scr_r <= d_scr; ptr_r <= d_ptr; scratch_r <= d_scratch;
                // A zero-length data stage uses up DATA1 at once.
                pid_r <= (s_rem != 7'd0);
                if (s_rem == 7'd0) res_r <= mk(ACT_ZLP, 7'd0, 1'b1, 1'b1, 7'd0, cfg_r);
              end
              default: res_r <= mk(ACT_STALL, 7'd0, 1'b0, 1'b0, 7'd0, cfg_r);
            endcase
          end
          OP_IN_DONE: begin
            if (!send_pkt && apply_r) begin
              apply_r <= 1'b0;
              res_r <= mk(ACT_SETADR, 7'd0, 1'b0, 1'b0, padr_r, cfg_r);
            end else if (!send_pkt) res_r <= mk(ACT_NONE, 7'd0, 1'b0, 1'b0, 7'd0, cfg_r);
          end
          OP_OUT_DONE: begin
            if (olen_r >= 10'd7 && !stall_r) begin
              lc_r <= pk_r[55:0];
              res_r <= mk(ACT_ZLP, 7'd0, 1'b1, 1'b0, 7'd0, cfg_r);
            end else res_r <= mk(ACT_NONE, 7'd0, 1'b0, 1'b0, 7'd0, cfg_r);
          end
          default: res_r <= mk(ACT_NONE, 7'd0, 1'b0, 1'b0, 7'd0, cfg_r);
        endcase
        if (op_r == OP_SETUP && dk == D_SEND && s_rem != 7'd0) begin
          n_r <= (s_rem > 7'(MAX_PACKET)) ? 7'(MAX_PACKET) : s_rem;
          fin_r <= (s_rem <= 7'(MAX_PACKET));
        end else begin
          n_r <= n_cur;
          fin_r <= (rem_r == n_cur);
        end
      end
      if (cmd.emit_pkt) begin
        res_r.action <= ACT_DATA;
        res_r.data_byte <= src;
        res_r.byte_index <= idx_r[5:0];
        res_r.packet_length <= n_r;
        res_r.pid_data1 <= pid_r;
        res_r.status_out_armed <= fin_r;
        res_r.device_address <= '0;
        res_r.is_configured <= cfg_r;
        res_r.last <= sts.pkt_done;
        idx_r <= idx_r + 7'd1;
        if (sts.pkt_done) begin
          ptr_r <= ptr_r + PW'(n_r);
          rem_r <= rem_r - n_r;
          pid_r <= ~pid_r;
          if (rem_r == n_r) active_r <= 1'b0;
        end
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r) else $error("result dropped");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_pkt |-> idx_r < n_r) else $error("byte index past packet");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_pkt |-> n_r <= 7'(MAX_PACKET) && n_r != 7'd0) else $error("bad packet length");

endmodule

FILE: sv/usb_control_endpoint_responder_unit.sv
// Endpoint 0 responder for a CDC ACM device. One event item (bus reset, setup,
// IN done, OUT done) yields one result item, or one item per byte of a descriptor
// or scratch packet of up to MAX_PACKET bytes. An event passes through the accept
// state and the decode state; a packet burst then sends its bytes one by one through
// the single byte path, and a held result stalls the controller. The last item of
// an event carries last. Depends on ucer_pkg, ucer_if, ucer_ctrl and ucer_dp.
module usb_control_endpoint_responder_unit import ucer_pkg::*; #(
  parameter int MAX_PACKET = MaxPacketDef,
  parameter int ROM_BYTES  = RomBytesDef
) (
  input logic clk,
  input logic rst_n,
  ucer_in_if.sink    in_ch,
  ucer_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic slot_free, in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  ucer_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .slot_free(slot_free),
    .sts(sts), .cmd(cmd), .in_ready(in_ch.ready)
  );

  ucer_dp #(.MAX_PACKET(MAX_PACKET), .ROM_BYTES(ROM_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .in_operation(in_ch.operation), .in_packet_bytes(in_ch.packet_bytes),
    .in_out_length(in_ch.out_length), .cmd(cmd), .sts(sts), .slot_free(slot_free),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );

endmodule
